>>> hdl/csma_pkg.sv
// csma_pkg: shared constants for the CSMA/CA backoff controller.
// Request codes, register indexes, reset values and default widths.
// No dependencies.
package csma_pkg;

   // default widths
   localparam int CSMA_CW_BITS    = 10;
   localparam int CSMA_TIMER_BITS = 16;
   localparam int CSMA_SLOT_BITS  = 8;
   localparam int CSMA_REQ_BITS   = 3;
   localparam int CSMA_RETRY_BITS = 4;
   localparam int CSMA_IDX_BITS   = 3;

   // request codes (req_tuser)
   localparam logic [CSMA_REQ_BITS-1:0] REQ_START    = 3'd0;
   localparam logic [CSMA_REQ_BITS-1:0] REQ_MEDIUM   = 3'd1;
   localparam logic [CSMA_REQ_BITS-1:0] REQ_TICK     = 3'd2;
   localparam logic [CSMA_REQ_BITS-1:0] REQ_TX_DONE  = 3'd3;
   localparam logic [CSMA_REQ_BITS-1:0] REQ_RX_FRAME = 3'd4;

   // control register indexes
   localparam logic [CSMA_IDX_BITS-1:0] CSR_IFS_TICKS  = 3'd0;
   localparam logic [CSMA_IDX_BITS-1:0] CSR_EIFS_TICKS = 3'd1;
   localparam logic [CSMA_IDX_BITS-1:0] CSR_SLOT_TICKS = 3'd2;
   localparam logic [CSMA_IDX_BITS-1:0] CSR_CW_MIN     = 3'd3;
   localparam logic [CSMA_IDX_BITS-1:0] CSR_CW_MAX     = 3'd4;

   // register reset values
   localparam int IFS_TICKS_RESET  = 34;
   localparam int EIFS_TICKS_RESET = 94;
   localparam int SLOT_TICKS_RESET = 9;
   localparam int CW_MIN_RESET     = 15;
   localparam int CW_MAX_RESET     = 1023;

endpackage

>>> hdl/csma_ca_backoff_controller.sv
// csma_ca_backoff_controller: DCF-style channel access engine (defer, IFS,
// backoff, transmit) with a request stream in and a status stream out.
// Depends on csma_pkg.
//
// A request passes through the input register, then the response register.
// Throughput: one request per cycle while the response stream is not stalled;
// the rate is set by the state update between the two registers.
// Reset (synchronous, active high): idle, medium busy, counters cleared,
// control registers at their defaults, both stream stages empty.
module csma_ca_backoff_controller
   import csma_pkg::*;
#(
   parameter int CW_BITS    = CSMA_CW_BITS,
   parameter int TIMER_BITS = CSMA_TIMER_BITS,
   localparam int REQ_DATA_W = ((6 + CW_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((5 + CW_BITS + 7) / 8) * 8,
   localparam int CSR_W = (TIMER_BITS > CW_BITS)
                        ? ((TIMER_BITS > CSMA_SLOT_BITS) ? TIMER_BITS : CSMA_SLOT_BITS)
                        : ((CW_BITS > CSMA_SLOT_BITS) ? CW_BITS : CSMA_SLOT_BITS)
) (
   input  logic                     clock,
   input  logic                     reset,
   // request stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_W-1:0]    req_tdata,  // medium_free, retry_count[3:0],
                                                // random_bits, fcs_ok, zero fill
   input  logic [CSMA_REQ_BITS-1:0] req_tuser,  // req_type
   // response stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_W-1:0]    rsp_tdata,  // access_state[2:0], send_frame,
                                                // tx_done, slots_left, zero fill
   // control register writes
   input  logic                     csr_we,
   input  logic [CSMA_IDX_BITS-1:0] csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   localparam int WIDE_W = CW_BITS + 16;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_DEFER    = 3'd1,
      ST_BACKOFF  = 3'd2,
      ST_TRANSMIT = 3'd3,
      ST_WAIT_IFS = 3'd4
   } state_type;

   // control registers
   logic [TIMER_BITS-1:0]     ifs_ticks_ff, eifs_ticks_ff;
   logic [CSMA_SLOT_BITS-1:0] slot_ticks_ff;
   logic [CW_BITS-1:0]        cw_min_ff, cw_max_ff;

   // input stage
   logic                       in_valid_ff, in_valid_in;
   logic [CSMA_REQ_BITS-1:0]   req_type_ff;
   logic                       medium_free_ff;
   logic [CSMA_RETRY_BITS-1:0] retry_count_ff;
   logic [CW_BITS-1:0]         random_bits_ff;
   logic                       fcs_ok_ff;

   // engine state
   state_type                 fsm_ff, fsm_in;
   logic                      medium_is_free_ff, medium_is_free_in;
   logic                      eifs_pending_ff, eifs_pending_in;
   logic [CW_BITS-1:0]        backoff_slots_ff, backoff_slots_in;
   logic [TIMER_BITS-1:0]     ifs_counter_ff, ifs_counter_in;
   logic [TIMER_BITS-1:0]     eifs_counter_ff, eifs_counter_in;
   logic [CSMA_SLOT_BITS-1:0] slot_counter_ff, slot_counter_in;

   // response stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_state_ff;
   logic               rsp_send_ff, rsp_done_ff;
   logic [CW_BITS-1:0] rsp_slots_ff;
   logic               send_in, done_in;

   // helpers
   logic                      req_xfer, advance;
   logic [WIDE_W-1:0]         cw_raw;
   logic [CW_BITS-1:0]        cw_eff;
   logic [TIMER_BITS-1:0]     eifs_dec, ifs_dec;
   logic [CSMA_SLOT_BITS-1:0] slot_len, slot_inc;
   logic [CW_BITS-1:0]        slots_dec;

   // handshake: the input stage moves on whenever the response slot frees up
   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_xfer   = req_tvalid & req_tready;
   assign in_valid_in  = req_xfer | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_slots_ff, rsp_done_ff, rsp_send_ff, rsp_state_ff});

   // contention window: min(((cw_min+1) << retry) - 1, cw_max)
   assign cw_raw = ((WIDE_W'(cw_min_ff) + WIDE_W'(1)) << retry_count_ff) - WIDE_W'(1);
   assign cw_eff = (cw_raw > WIDE_W'(cw_max_ff)) ? cw_max_ff : cw_raw[CW_BITS-1:0];

   // tick arithmetic
   assign eifs_dec  = (eifs_counter_ff != '0) ? eifs_counter_ff - 1'b1 : eifs_counter_ff;
   assign ifs_dec   = (ifs_counter_ff != '0) ? ifs_counter_ff - 1'b1 : ifs_counter_ff;
   assign slot_len  = (slot_ticks_ff == '0) ? CSMA_SLOT_BITS'(1) : slot_ticks_ff;
   assign slot_inc  = slot_counter_ff + 1'b1;
   assign slots_dec = backoff_slots_ff - 1'b1;

   // next state for the request held in the input stage
   always_comb begin
      fsm_in            = fsm_ff;
      medium_is_free_in = medium_is_free_ff;
      eifs_pending_in   = eifs_pending_ff;
      backoff_slots_in  = backoff_slots_ff;
      ifs_counter_in    = ifs_counter_ff;
      eifs_counter_in   = eifs_counter_ff;
      slot_counter_in   = slot_counter_ff;
      send_in           = 1'b0;
      done_in           = 1'b0;
      case (req_type_ff)
         REQ_START: begin
            if (fsm_ff == ST_IDLE) begin
               backoff_slots_in = random_bits_ff & cw_eff;
               if (medium_is_free_ff) begin
                  fsm_in         = ST_WAIT_IFS;
                  ifs_counter_in = ifs_ticks_ff;
                  if (eifs_pending_ff) eifs_counter_in = eifs_ticks_ff;
               end else begin
                  fsm_in = ST_DEFER;
               end
            end
         end
         REQ_MEDIUM: begin
            medium_is_free_in = medium_free_ff;
            if (fsm_ff == ST_DEFER && medium_free_ff) begin
               fsm_in         = ST_WAIT_IFS;
               ifs_counter_in = ifs_ticks_ff;
               if (eifs_pending_ff) eifs_counter_in = eifs_ticks_ff;
            end else if (fsm_ff == ST_WAIT_IFS && !medium_free_ff) begin
               fsm_in         = ST_DEFER;
               ifs_counter_in = '0;
            end else if (fsm_ff == ST_BACKOFF && !medium_free_ff) begin
               // frozen: completed slots stay, partial slot is dropped
               fsm_in          = ST_DEFER;
               slot_counter_in = '0;
            end
         end
         REQ_TICK: begin
            eifs_counter_in = eifs_dec;
            if (fsm_ff == ST_WAIT_IFS) begin
               ifs_counter_in = ifs_dec;
               if (ifs_dec == '0 && eifs_dec == '0) begin
                  fsm_in          = ST_BACKOFF;
                  slot_counter_in = '0;
               end
            end else if (fsm_ff == ST_BACKOFF) begin
               if (backoff_slots_ff == '0) begin
                  fsm_in  = ST_TRANSMIT;
                  send_in = 1'b1;
               end else if (slot_inc >= slot_len) begin
                  slot_counter_in  = '0;
                  backoff_slots_in = slots_dec;
                  if (slots_dec == '0) begin
                     fsm_in  = ST_TRANSMIT;
                     send_in = 1'b1;
                  end
               end else begin
                  slot_counter_in = slot_inc;
               end
            end
         end
         REQ_TX_DONE: begin
            if (fsm_ff == ST_TRANSMIT) begin
               fsm_in  = ST_IDLE;
               done_in = 1'b1;
            end
         end
         REQ_RX_FRAME: begin
            eifs_pending_in = ~fcs_ok_ff;
         end
         default: begin
         end
      endcase
   end

   // all registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ifs_ticks_ff      <= TIMER_BITS'(IFS_TICKS_RESET);
         eifs_ticks_ff     <= TIMER_BITS'(EIFS_TICKS_RESET);
         slot_ticks_ff     <= CSMA_SLOT_BITS'(SLOT_TICKS_RESET);
         cw_min_ff         <= CW_BITS'(CW_MIN_RESET);
         cw_max_ff         <= CW_BITS'(CW_MAX_RESET);
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         fsm_ff            <= ST_IDLE;
         medium_is_free_ff <= 1'b0;
         eifs_pending_ff   <= 1'b0;
         backoff_slots_ff  <= '0;
         ifs_counter_ff    <= '0;
         eifs_counter_ff   <= '0;
         slot_counter_ff   <= '0;
      end else begin
         // control register writes; unknown indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_IFS_TICKS:  ifs_ticks_ff  <= csr_wdata[TIMER_BITS-1:0];
               CSR_EIFS_TICKS: eifs_ticks_ff <= csr_wdata[TIMER_BITS-1:0];
               CSR_SLOT_TICKS: slot_ticks_ff <= csr_wdata[CSMA_SLOT_BITS-1:0];
               CSR_CW_MIN:     cw_min_ff     <= csr_wdata[CW_BITS-1:0];
               CSR_CW_MAX:     cw_max_ff     <= csr_wdata[CW_BITS-1:0];
               default: begin
               end
            endcase
         end

         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;

         // capture request payload
         if (req_xfer) begin
            req_type_ff    <= req_tuser;
            medium_free_ff <= req_tdata[0];
            retry_count_ff <= req_tdata[CSMA_RETRY_BITS:1];
            random_bits_ff <= req_tdata[CSMA_RETRY_BITS+CW_BITS:CSMA_RETRY_BITS+1];
            fcs_ok_ff      <= req_tdata[CSMA_RETRY_BITS+CW_BITS+1];
         end

         // commit the state update and its response
         if (advance) begin
            fsm_ff            <= fsm_in;
            medium_is_free_ff <= medium_is_free_in;
            eifs_pending_ff   <= eifs_pending_in;
            backoff_slots_ff  <= backoff_slots_in;
            ifs_counter_ff    <= ifs_counter_in;
            eifs_counter_ff   <= eifs_counter_in;
            slot_counter_ff   <= slot_counter_in;
            rsp_state_ff      <= fsm_in;
            rsp_send_ff       <= send_in;
            rsp_done_ff       <= done_in;
            rsp_slots_ff      <= backoff_slots_in;
         end
      end
   end

endmodule

>>> verif/csma_ca_backoff_controller_tb.sv
// csma_ca_backoff_controller_tb: self-checking bench for the CSMA/CA backoff controller.
// Predicts each status transfer from its own channel-access model and compares it field by field.
// Depends on csma_pkg and hdl/csma_ca_backoff_controller.sv.
module csma_ca_backoff_controller_tb;
   import csma_pkg::*;

   localparam int CYCLE            = 12;
   localparam int RUN_LIMIT_CYCLES = 400000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int MAX_REPORTS      = 10;

   // request codes the block must ignore
   localparam logic [CSMA_REQ_BITS-1:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [CSMA_REQ_BITS-1:0] REQ_UNUSED_LAST  = 3'd7;

   typedef enum logic [2:0] {
      ACC_IDLE     = 3'd0,
      ACC_DEFER    = 3'd1,
      ACC_BACKOFF  = 3'd2,
      ACC_TRANSMIT = 3'd3,
      ACC_WAIT_IFS = 3'd4
   } access_state_type;

   typedef struct {
      logic [CSMA_REQ_BITS-1:0] kind;
      logic                     medium_free;
      logic [3:0]               retry;
      logic [9:0]               rnd;
      logic                     fcs_ok;
   } access_req_type;

   typedef struct {
      access_state_type state;
      logic             send_frame;
      logic             tx_done;
      logic [9:0]       slots_left;
   } access_status_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // medium_free, retry_count[3:0], random_bits[9:0], fcs_ok
   logic [2:0]  req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // access_state[2:0], send_frame, tx_done, slots_left[9:0], zero fill
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   // channel-access model state
   access_state_type acc_state;
   logic             medium_free_q;
   logic             eifs_armed;
   logic [9:0]       slots_q;
   logic [15:0]      ifs_count;
   logic [15:0]      eifs_count;
   logic [7:0]       slot_count;
   logic [15:0]      cfg_ifs;
   logic [15:0]      cfg_eifs;
   logic [7:0]       cfg_slot;
   logic [9:0]       cfg_cw_min;
   logic [9:0]       cfg_cw_max;

   access_status_type expected_status_q[$];
   int                error_count = 0;
   bit                req_gaps_on;
   bit                rsp_stalls_on;
   int                rsp_hold_cycles;

   csma_ca_backoff_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CYCLE / 2) clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic void reset_access_model();
      acc_state     = ACC_IDLE;
      medium_free_q = 1'b0;
      eifs_armed    = 1'b0;
      slots_q       = '0;
      ifs_count     = '0;
      eifs_count    = '0;
      slot_count    = '0;
      cfg_ifs       = 16'(IFS_TICKS_RESET);
      cfg_eifs      = 16'(EIFS_TICKS_RESET);
      cfg_slot      = 8'(SLOT_TICKS_RESET);
      cfg_cw_min    = 10'(CW_MIN_RESET);
      cfg_cw_max    = 10'(CW_MAX_RESET);
   endfunction

   // window grows with the retry number, clamped before it is used as a mask
   function automatic logic [9:0] contention_window(input logic [3:0] retry);
      logic [31:0] w;
      w = ((32'(cfg_cw_min) + 32'd1) << retry) - 32'd1;
      if (w > 32'(cfg_cw_max))
         w = 32'(cfg_cw_max);
      return w[9:0];
   endfunction

   function automatic void enter_wait_ifs();
      acc_state = ACC_WAIT_IFS;
      ifs_count = cfg_ifs;
      if (eifs_armed)
         eifs_count = cfg_eifs;
   endfunction

   function automatic access_status_type predict_access_step(input access_req_type r);
      access_status_type s;
      logic [7:0]        slot_len;
      s.send_frame = 1'b0;
      s.tx_done    = 1'b0;
      case (r.kind)
         REQ_START: begin
            if (acc_state == ACC_IDLE) begin
               slots_q = r.rnd & contention_window(r.retry);
               if (medium_free_q)
                  enter_wait_ifs();
               else
                  acc_state = ACC_DEFER;
            end
         end
         REQ_MEDIUM: begin
            medium_free_q = r.medium_free;
            if (acc_state == ACC_DEFER && r.medium_free) begin
               enter_wait_ifs();
            end else if (acc_state == ACC_WAIT_IFS && !r.medium_free) begin
               acc_state = ACC_DEFER;
               ifs_count = '0;
            end else if (acc_state == ACC_BACKOFF && !r.medium_free) begin
               // completed slots are kept, the partial one is dropped
               acc_state  = ACC_DEFER;
               slot_count = '0;
            end
         end
         REQ_TICK: begin
            if (eifs_count != 0)
               eifs_count = eifs_count - 16'd1;
            if (acc_state == ACC_WAIT_IFS) begin
               if (ifs_count != 0)
                  ifs_count = ifs_count - 16'd1;
               if (ifs_count == 0 && eifs_count == 0) begin
                  acc_state  = ACC_BACKOFF;
                  slot_count = '0;
               end
            end else if (acc_state == ACC_BACKOFF) begin
               if (slots_q == 0) begin
                  acc_state    = ACC_TRANSMIT;
                  s.send_frame = 1'b1;
               end else begin
                  slot_len   = (cfg_slot == 0) ? 8'd1 : cfg_slot;
                  slot_count = slot_count + 8'd1;
                  if (slot_count >= slot_len) begin
                     slot_count = '0;
                     slots_q    = slots_q - 10'd1;
                     if (slots_q == 0) begin
                        acc_state    = ACC_TRANSMIT;
                        s.send_frame = 1'b1;
                     end
                  end
               end
            end
         end
         REQ_TX_DONE: begin
            if (acc_state == ACC_TRANSMIT) begin
               acc_state = ACC_IDLE;
               s.tx_done = 1'b1;
            end
         end
         REQ_RX_FRAME: eifs_armed = !r.fcs_ok;
         default: ;
      endcase
      s.state      = acc_state;
      s.slots_left = slots_q;
      return s;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic access_req_type make_request(input logic [2:0] kind, input logic mf,
                                                   input logic [3:0] retry,
                                                   input logic [9:0] rnd,
                                                   input logic fcs);
      access_req_type r;
      r.kind        = kind;
      r.medium_free = mf;
      r.retry       = retry;
      r.rnd         = rnd;
      r.fcs_ok      = fcs;
      return r;
   endfunction

   // mostly the request that moves the current state forward, some noise
   function automatic access_req_type pick_request(input bit with_noise);
      access_req_type r;
      int             roll;
      r = make_request(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                       4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)),
                       1'($urandom_range(0, 1)));
      if (with_noise && $urandom_range(0, 99) < 12)
         return r;
      roll = $urandom_range(0, 99);
      case (acc_state)
         ACC_IDLE: r.kind = (roll < 90) ? REQ_START : REQ_RX_FRAME;
         ACC_DEFER: begin
            if (roll < 70) begin
               r.kind = REQ_MEDIUM;
               r.medium_free = 1'b1;
            end else if (roll < 85) begin
               r.kind = REQ_TICK;
            end else if (roll < 95) begin
               r.kind = REQ_MEDIUM;
               r.medium_free = 1'b0;
            end else begin
               r.kind = REQ_RX_FRAME;
            end
         end
         ACC_WAIT_IFS: begin
            if (roll < 85) begin
               r.kind = REQ_TICK;
            end else if (roll < 93) begin
               r.kind = REQ_MEDIUM;
               r.medium_free = 1'b0;
            end else begin
               r.kind = REQ_RX_FRAME;
            end
         end
         ACC_BACKOFF: begin
            if (roll < 88) begin
               r.kind = REQ_TICK;
            end else begin
               r.kind = REQ_MEDIUM;
               r.medium_free = (roll >= 96);
            end
         end
         ACC_TRANSMIT: begin
            if (roll < 70)
               r.kind = REQ_TX_DONE;
            else if (roll < 85)
               r.kind = REQ_TICK;
            else
               r.kind = REQ_START;
         end
         default: ;
      endcase
      return r;
   endfunction

   // one request transfer, with an optional idle burst in front
   task automatic send_request(input access_req_type r);
      int gap;
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {r.fcs_ok, r.rnd, r.retry, r.medium_free};
      do @(posedge clock); while (!req_tready);
      expected_status_q.push_back(predict_access_step(r));
   endtask

   task automatic run_traffic(input int count, input bit with_noise);
      repeat (count) send_request(pick_request(with_noise));
   endtask

   // stop offering and let every expected status come back
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_timing(input logic [15:0] ifs, input logic [15:0] eifs,
                                 input logic [7:0] slot, input logic [9:0] cw_lo,
                                 input logic [9:0] cw_hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_IFS_TICKS;
      csr_wdata <= ifs;
      @(posedge clock);
      csr_index <= CSR_EIFS_TICKS;
      csr_wdata <= eifs;
      @(posedge clock);
      csr_index <= CSR_SLOT_TICKS;
      csr_wdata <= {8'h00, slot};
      @(posedge clock);
      csr_index <= CSR_CW_MIN;
      csr_wdata <= {6'h00, cw_lo};
      @(posedge clock);
      csr_index <= CSR_CW_MAX;
      csr_wdata <= {6'h00, cw_hi};
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_ifs    = ifs;
      cfg_eifs   = eifs;
      cfg_slot   = slot;
      cfg_cw_min = cw_lo;
      cfg_cw_max = cw_hi;
   endtask

   task automatic program_small_timing();
      program_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                     8'($urandom_range(0, 3)), 10'($urandom_range(0, 15)),
                     10'($urandom_range(0, 15)));
   endtask

   // ---------------------------------------------------------------- tests
   // register defaults, ignored requests and unknown codes
   task automatic test_reset_values();
      send_request(make_request(REQ_TX_DONE, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_UNUSED_FIRST, 1'b1, 4'hF, 10'h3FF, 1'b1));
      send_request(make_request(REQ_UNUSED_LAST, 1'b1, 4'hF, 10'h3FF, 1'b1));
      // default window of 15 leaves one slot; medium is busy out of reset
      send_request(make_request(REQ_START, 1'b0, 4'd0, 10'h3F1, 1'b1));
      send_request(make_request(REQ_START, 1'b1, 4'hF, 10'h3FF, 1'b0));
      send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_MEDIUM, 1'b1, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_MEDIUM, 1'b0, 4'd0, 10'd0, 1'b0));
   endtask

   // zero slot length counts as one; shifted window clamps to the maximum
   task automatic test_window_clamp();
      wait_for_quiet();
      program_timing(16'd1, 16'd2, 8'd0, 10'h3FF, 10'd3);
      send_request(make_request(REQ_MEDIUM, 1'b1, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TX_DONE, 1'b0, 4'd0, 10'd0, 1'b0));
      // bad FCS arms the extended space for the next wait
      send_request(make_request(REQ_RX_FRAME, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_START, 1'b0, 4'hF, 10'h3FF, 1'b0));
      repeat (5) send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TX_DONE, 1'b0, 4'd0, 10'd0, 1'b0));
   endtask

   // empty window: backoff with no slots transmits on the first tick
   task automatic test_zero_window();
      wait_for_quiet();
      program_timing(16'd0, 16'd0, 8'd1, 10'd0, 10'd0);
      send_request(make_request(REQ_START, 1'b0, 4'hF, 10'h3FF, 1'b0));
      send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_MEDIUM, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TX_DONE, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_RX_FRAME, 1'b0, 4'd0, 10'd0, 1'b1));
   endtask

   // widest timers, then a busy medium freezing a partial slot
   task automatic test_long_timers();
      wait_for_quiet();
      program_timing(16'hFFFF, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF);
      send_request(make_request(REQ_START, 1'b0, 4'd0, 10'd1, 1'b0));
      send_request(make_request(REQ_MEDIUM, 1'b1, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_MEDIUM, 1'b0, 4'd0, 10'd0, 1'b0));
      wait_for_quiet();
      program_timing(16'd0, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF);
      send_request(make_request(REQ_MEDIUM, 1'b1, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
      send_request(make_request(REQ_MEDIUM, 1'b0, 4'd0, 10'd0, 1'b0));
   endtask

   task automatic test_random_traffic();
      repeat (6) begin
         wait_for_quiet();
         program_small_timing();
         req_gaps_on   = $urandom_range(0, 2) != 0;
         rsp_stalls_on = $urandom_range(0, 2) != 0;
         run_traffic(180, 1'b1);
      end
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_output_backpressure();
      req_gaps_on     = 1'b0;
      rsp_stalls_on   = 1'b0;
      rsp_hold_cycles = 64;
      run_traffic(30, 1'b0);
   endtask

   // full-width slot counter with windows of at most one slot
   task automatic test_slot_wrap();
      wait_for_quiet();
      program_timing(16'($urandom_range(0, 2)), 16'($urandom_range(0, 3)), 8'hFF,
                     10'd0, 10'd1);
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      run_traffic(250, 1'b1);
   endtask

   task automatic test_minimum_timing();
      wait_for_quiet();
      program_timing(16'd0, 16'd0, 8'd0, 10'd0, 10'd0);
      run_traffic(120, 1'b1);
   endtask

   task automatic test_steady_stream();
      wait_for_quiet();
      program_small_timing();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      run_traffic(150, 1'b1);
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin : test_sequence
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      reset_access_model();
      req_gaps_on     = 1'b1;
      rsp_stalls_on   = 1'b1;
      rsp_hold_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_window_clamp();
      test_zero_window();
      test_long_timers();
      test_random_traffic();
      test_output_backpressure();
      test_slot_wrap();
      test_minimum_timing();
      test_steady_stream();
      wait_for_quiet();

      if (error_count == 0 && expected_status_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // result-side ready: random stall bursts plus an optional long hold-off
   initial begin : rsp_ready_drive
      int burst;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare every status transfer with the oldest prediction
   always @(posedge clock) begin : status_check
      access_status_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_status_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected status transfer: tdata %h", rsp_tdata);
         end else begin
            want = expected_status_q.pop_front();
            if (rsp_tdata[2:0] !== want.state || rsp_tdata[3] !== want.send_frame ||
                rsp_tdata[4] !== want.tx_done || rsp_tdata[14:5] !== want.slots_left ||
                rsp_tdata[15] !== 1'b0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"status mismatch: expected state %0d send %0b done %0b slots %0d,",
                            " got state %0d send %0b done %0b slots %0d fill %0b"},
                           want.state, want.send_frame, want.tx_done, want.slots_left,
                           rsp_tdata[2:0], rsp_tdata[3], rsp_tdata[4], rsp_tdata[14:5],
                           rsp_tdata[15]);
            end
         end
      end
   end

   initial begin : watchdog
      #(CYCLE * RUN_LIMIT_CYCLES);
      $display("tb: failure");
      $finish;
   end

endmodule
